### sv/jsq_pkg.sv
// ----------------------------------------------------------------------------
// jsq_pkg
// Types and fixed constants shared by the join-shortest-queue dispatcher.
// ----------------------------------------------------------------------------
package jsq_pkg;

  localparam int STAMP_W     = 16;
  localparam int SVC_IN_W    = 4;
  localparam int SVC_INPUTS  = 4;
  localparam int JOIN_W      = 2;
  localparam int STARTED_W   = 3;
  localparam int SERVED_W    = 32;
  localparam int TOTAL_W     = 48;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = 3;
  localparam int FIFO_CNT_W  = 4;

  typedef struct packed {
    logic                arrival;
    logic [SVC_IN_W-1:0] service_time_0;
    logic [SVC_IN_W-1:0] service_time_1;
    logic [SVC_IN_W-1:0] service_time_2;
    logic [SVC_IN_W-1:0] service_time_3;
  } jsq_in_t;

  typedef struct packed {
    logic [JOIN_W-1:0]    joined_line;
    logic                 arrival_dropped;
    logic [STARTED_W-1:0] started_this_tick;
    logic [STAMP_W-1:0]   current_tick;
    logic [SERVED_W-1:0]  total_served;
    logic [TOTAL_W-1:0]   total_wait;
    logic [TOTAL_W-1:0]   total_length;
  } jsq_out_t;

  typedef struct packed {
    logic                start;
    logic [STAMP_W-1:0]  wait_ticks;
  } jsq_lane_res_t;

  typedef struct packed {
    logic [JOIN_W-1:0]   joined_line;
    logic                arrival_dropped;
    logic [STAMP_W-1:0]  current_tick;
  } jsq_meta_t;

endpackage

### sv/jsq_if.sv
// ----------------------------------------------------------------------------
// jsq_in_if / jsq_out_if
// Valid/ready channels that carry one input item and one result item.
// ----------------------------------------------------------------------------
interface jsq_in_if;
  logic             valid;
  logic             ready;
  jsq_pkg::jsq_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jsq_out_if;
  logic              valid;
  logic              ready;
  jsq_pkg::jsq_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/jsq_ram.sv
// ----------------------------------------------------------------------------
// jsq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module jsq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### sv/jsq_lane.sv
// ----------------------------------------------------------------------------
// jsq_lane
// One line and its server: FIFO of arrival stamps with a cached head, busy
// timer, and the wait of an item that starts service this tick.
// ----------------------------------------------------------------------------
module jsq_lane #(
  parameter int LINE_DEPTH    = 16,
  parameter int SERVICE_WIDTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  push,
  input  logic [jsq_pkg::STAMP_W-1:0]           tick,
  input  logic [SERVICE_WIDTH-1:0]              svc,
  output logic [$clog2(LINE_DEPTH+1)-1:0]       count_r,
  output jsq_pkg::jsq_lane_res_t                res_r
);
  import jsq_pkg::*;

  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int PTR_W = $clog2(LINE_DEPTH);

  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]         rd_plus1, wr_plus1;
  logic [CNT_W-1:0]         count_nxt, cnt_pp;
  logic [SERVICE_WIDTH-1:0] busy_r, busy_nxt;
  logic [STAMP_W-1:0]       head_r, head_nxt, head_cur, ram_q, stamp;
  logic                     use_q_r, use_q_nxt;
  logic                     pop;
  jsq_lane_res_t            res_nxt;

  jsq_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (en && push),
    .waddr   (wr_ptr_r),
    .wdata   (tick),
    .raddr   (rd_plus1),
    .rdata_r (ram_q)
  );

  always_comb begin
    rd_plus1 = (rd_ptr_r == PTR_W'(LINE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    wr_plus1 = (wr_ptr_r == PTR_W'(LINE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    head_cur = use_q_r ? ram_q : head_r;
    cnt_pp   = count_r + CNT_W'(push);
    pop      = en && (busy_r == '0) && (cnt_pp != '0);
    stamp    = (count_r == '0) ? tick : head_cur;

    res_nxt.start      = pop;
    res_nxt.wait_ticks = tick - stamp;

    count_nxt  = count_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    busy_nxt   = busy_r;
    use_q_nxt  = 1'b0;
    head_nxt   = head_cur;
    if (en) begin
      count_nxt = cnt_pp - CNT_W'(pop);
      if (push) begin
        wr_ptr_nxt = wr_plus1;
      end
      if (pop) begin
        rd_ptr_nxt = rd_plus1;
      end
      if (busy_r != '0) begin
        busy_nxt = busy_r - 1'b1;
      end else if (pop) begin
        busy_nxt = svc;
      end
      if (pop && (count_r >= CNT_W'(2))) begin
        use_q_nxt = 1'b1;
      end else if ((count_r == '0) || (pop && (count_r == CNT_W'(1)))) begin
        head_nxt = tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      busy_r   <= '0;
      use_q_r  <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      busy_r   <= busy_nxt;
      use_q_r  <= use_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    if (en) begin
      res_r <= res_nxt;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LINE_DEPTH))
    else $error("Line count exceeds the line depth.");

  a_cached_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    use_q_r |-> (count_r != '0))
    else $error("Head taken from memory while the line is empty.");

  a_busy_blocks_start: assert property (@(posedge clk) disable iff (!rst_n)
    (en && (busy_r != '0)) |=> !res_r.start)
    else $error("A busy server started an item.");

endmodule

### sv/jsq_merge.sv
// ----------------------------------------------------------------------------
// jsq_merge
// Combines the lane results of one tick and keeps the saturating totals.
// ----------------------------------------------------------------------------
module jsq_merge #(
  parameter int NUM_LINES  = 4,
  parameter int LINE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s1_valid,
  input  jsq_pkg::jsq_meta_t                  s1_meta,
  input  jsq_pkg::jsq_lane_res_t              lane_res [NUM_LINES],
  input  logic [$clog2(LINE_DEPTH+1)-1:0]     lane_cnt [NUM_LINES],
  output logic                                out_valid_r,
  output jsq_pkg::jsq_out_t                   out_r
);
  import jsq_pkg::*;

  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int WS_W  = STAMP_W + $clog2(NUM_LINES);
  localparam int LS_W  = $clog2(NUM_LINES * LINE_DEPTH + 1);
  localparam int ST_W  = $clog2(NUM_LINES + 1);

  logic [WS_W-1:0]     wsum_r, wsum_nxt;
  logic [LS_W-1:0]     lsum_r, lsum_nxt;
  logic [ST_W-1:0]     nst_r, nst_nxt;
  jsq_meta_t           meta_r;
  logic                s2_v_r;

  logic [SERVED_W-1:0] served_r, served_nxt;
  logic [TOTAL_W-1:0]  wacc_r, wacc_nxt;
  logic [TOTAL_W-1:0]  lacc_r, lacc_nxt;
  logic [SERVED_W:0]   served_sum;
  logic [TOTAL_W:0]    wacc_sum, lacc_sum;

  always_comb begin
    wsum_nxt = '0;
    lsum_nxt = '0;
    nst_nxt  = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (lane_res[i].start) begin
        wsum_nxt = wsum_nxt + WS_W'(lane_res[i].wait_ticks);
      end
      lsum_nxt = lsum_nxt + LS_W'(lane_cnt[i]);
      nst_nxt  = nst_nxt + ST_W'(lane_res[i].start);
    end
  end

  always_comb begin
    served_sum = {1'b0, served_r} + (SERVED_W + 1)'(nst_r);
    wacc_sum   = {1'b0, wacc_r} + (TOTAL_W + 1)'(wsum_r);
    lacc_sum   = {1'b0, lacc_r} + (TOTAL_W + 1)'(lsum_r);
    served_nxt = served_sum[SERVED_W] ? '1 : served_sum[SERVED_W-1:0];
    wacc_nxt   = wacc_sum[TOTAL_W] ? '1 : wacc_sum[TOTAL_W-1:0];
    lacc_nxt   = lacc_sum[TOTAL_W] ? '1 : lacc_sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      served_r    <= '0;
      wacc_r      <= '0;
      lacc_r      <= '0;
    end else begin
      s2_v_r      <= s1_valid;
      out_valid_r <= s2_v_r;
      if (s2_v_r) begin
        served_r <= served_nxt;
        wacc_r   <= wacc_nxt;
        lacc_r   <= lacc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      wsum_r <= wsum_nxt;
      lsum_r <= lsum_nxt;
      nst_r  <= nst_nxt;
      meta_r <= s1_meta;
    end
    if (s2_v_r) begin
      out_r.joined_line       <= meta_r.joined_line;
      out_r.arrival_dropped   <= meta_r.arrival_dropped;
      out_r.started_this_tick <= STARTED_W'(nst_r);
      out_r.current_tick      <= meta_r.current_tick;
      out_r.total_served      <= served_nxt;
      out_r.total_wait        <= wacc_nxt;
      out_r.total_length      <= lacc_nxt;
    end
  end

  a_served_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |=> (served_r >= $past(served_r)))
    else $error("Served total decreased.");

  a_wait_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |=> (wacc_r >= $past(wacc_r)))
    else $error("Wait total decreased.");

  a_len_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |=> (lacc_r >= $past(lacc_r)))
    else $error("Length total decreased.");

endmodule

### sv/join_shortest_queue_dispatcher_core.sv
// ----------------------------------------------------------------------------
// join_shortest_queue_dispatcher_core
// Multi-server dispatcher that sends each arrival to the shortest line.
//
// Each input item on in_chan is one time tick: an arrival flag and one
// service time per server. Each tick yields exactly one result item on
// out_chan with the chosen line, the drop flag, the number of servers that
// started, the tick number and the saturating running totals.
// One item is accepted per cycle while in_chan.ready is high. The line and server
// state is updated in the accept cycle by one lane per line; two more register
// stages add up the lane results and update the totals, and each result then
// passes through the output buffer before it is offered.
// Results wait in an eight-entry output buffer. in_chan.ready drops only when
// eight items are accepted and not yet taken, so a receiver that takes every
// result keeps the input at full rate, and a stalled receiver holds the input
// after that many items and nothing is lost.
// Reset clears all lines, timers, the tick count, the totals and the buffer;
// the block accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
module join_shortest_queue_dispatcher_core #(
  parameter int NUM_LINES     = 4,
  parameter int LINE_DEPTH    = 16,
  parameter int SERVICE_WIDTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  jsq_in_if.sink    in_chan,
  jsq_out_if.source out_chan
);
  import jsq_pkg::*;

  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int IDX_W = $clog2(NUM_LINES);

  logic                  in_accept, out_take;
  logic [STAMP_W-1:0]    tick_r;
  logic [SVC_IN_W-1:0]   svc_in [SVC_INPUTS];
  logic [CNT_W-1:0]      lane_cnt [NUM_LINES];
  jsq_lane_res_t         lane_res [NUM_LINES];
  logic [IDX_W-1:0]      best;
  logic [CNT_W-1:0]      best_cnt;
  logic                  dropped;
  jsq_meta_t             meta_nxt, s1_meta_r;
  logic                  s1_v_r;

  logic                  mrg_valid;
  jsq_out_t              mrg_out;
  jsq_out_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] fwr_r, frd_r;
  logic [FIFO_CNT_W-1:0] fifo_cnt_r, credit_r;

  assign in_accept = in_chan.valid && in_chan.ready;
  assign out_take  = out_chan.valid && out_chan.ready;

  assign svc_in[0] = in_chan.data.service_time_0;
  assign svc_in[1] = in_chan.data.service_time_1;
  assign svc_in[2] = in_chan.data.service_time_2;
  assign svc_in[3] = in_chan.data.service_time_3;

  always_comb begin
    best     = '0;
    best_cnt = lane_cnt[0];
    for (int i = 1; i < NUM_LINES; i++) begin
      if (best_cnt > lane_cnt[i]) begin
        best     = IDX_W'(i);
        best_cnt = lane_cnt[i];
      end
    end
    dropped = in_chan.data.arrival && (best_cnt == CNT_W'(LINE_DEPTH));

    meta_nxt.joined_line     = in_chan.data.arrival ? JOIN_W'(best) : '0;
    meta_nxt.arrival_dropped = dropped;
    meta_nxt.current_tick    = tick_r;
  end

  for (genvar g = 0; g < NUM_LINES; g++) begin : g_lane
    logic [STAMP_W-1:0]       svc_ext;
    logic [SERVICE_WIDTH-1:0] svc;
    logic                     push;

    if (g < SVC_INPUTS) begin : g_svc
      assign svc_ext = {{(STAMP_W - SVC_IN_W){1'b0}}, svc_in[g]};
    end else begin : g_nosvc
      assign svc_ext = '0;
    end
    assign svc  = svc_ext[SERVICE_WIDTH-1:0];
    assign push = in_chan.data.arrival && !dropped && (best == IDX_W'(g));

    jsq_lane #(
      .LINE_DEPTH    (LINE_DEPTH),
      .SERVICE_WIDTH (SERVICE_WIDTH)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (in_accept),
      .push    (push),
      .tick    (tick_r),
      .svc     (svc),
      .count_r (lane_cnt[g]),
      .res_r   (lane_res[g])
    );
  end

  jsq_merge #(
    .NUM_LINES  (NUM_LINES),
    .LINE_DEPTH (LINE_DEPTH)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_v_r),
    .s1_meta     (s1_meta_r),
    .lane_res    (lane_res),
    .lane_cnt    (lane_cnt),
    .out_valid_r (mrg_valid),
    .out_r       (mrg_out)
  );

  assign in_chan.ready  = (credit_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign out_chan.valid = (fifo_cnt_r != '0);
  assign out_chan.data  = fifo_mem[frd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      s1_v_r     <= 1'b0;
      fwr_r      <= '0;
      frd_r      <= '0;
      fifo_cnt_r <= '0;
      credit_r   <= '0;
    end else begin
      s1_v_r <= in_accept;
      if (in_accept) begin
        tick_r <= tick_r + 1'b1;
      end
      if (mrg_valid) begin
        fwr_r <= fwr_r + 1'b1;
      end
      if (out_take) begin
        frd_r <= frd_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + FIFO_CNT_W'(mrg_valid) - FIFO_CNT_W'(out_take);
      credit_r   <= credit_r + FIFO_CNT_W'(in_accept) - FIFO_CNT_W'(out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_meta_r <= meta_nxt;
    end
    if (mrg_valid) begin
      fifo_mem[fwr_r] <= mrg_out;
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("More items in flight than the output buffer holds.");

  a_buffer_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= credit_r)
    else $error("Output buffer holds more results than accepted items.");

  a_no_buffer_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_valid |-> (fifo_cnt_r != FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("Result written into a full output buffer.");

  a_accept_reaches_merge: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##3 mrg_valid)
    else $error("Accepted item did not produce a result after three cycles.");

endmodule

### tb/sv/jsq_dispatch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsq_dispatch_checker
// Tracks the dispatcher's lines and servers and checks every result item.
//
// Each item accepted on the input channel is run through a tick-level model of
// the lines, server timers and saturating totals. The predicted report is
// queued. Each result item taken from the output channel is compared field by
// field with the oldest queued report.
// ----------------------------------------------------------------------------
module jsq_dispatch_checker
  import jsq_pkg::*;
#(
  parameter int NUM_LINES     = 4,
  parameter int LINE_DEPTH    = 16,
  parameter int SERVICE_WIDTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  jsq_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  jsq_out_t out_data,
  output int       err_count,
  output int       pending
);

  localparam logic [63:0] SERVED_CAP = (64'd1 << SERVED_W) - 64'd1;
  localparam logic [63:0] TOTAL_CAP  = (64'd1 << TOTAL_W) - 64'd1;
  localparam logic [63:0] SVC_MASK   = (64'd1 << SERVICE_WIDTH) - 64'd1;

  logic [STAMP_W-1:0]  stamp_mem [NUM_LINES][LINE_DEPTH];
  int unsigned         head_idx  [NUM_LINES];
  int unsigned         line_fill [NUM_LINES];
  int unsigned         busy_left [NUM_LINES];
  logic [STAMP_W-1:0]  tick_now;
  logic [SERVED_W-1:0] served_total;
  logic [TOTAL_W-1:0]  wait_total;
  logic [TOTAL_W-1:0]  length_total;
  jsq_out_t            report_q [$];
  jsq_out_t            want;

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] cap);
    if (a >= cap || b > cap - a) begin
      return cap;
    end
    return a + b;
  endfunction

  // Advances the line and server state by one tick and returns its report.
  function jsq_out_t dispatch_tick(jsq_in_t t);
    jsq_out_t            r;
    int unsigned         best;
    int unsigned         slot;
    int unsigned         queued;
    logic [SVC_IN_W-1:0] svc [SVC_INPUTS];
    logic [STAMP_W-1:0]  waited;
    r = '0;
    r.current_tick = tick_now;
    svc[0] = t.service_time_0;
    svc[1] = t.service_time_1;
    svc[2] = t.service_time_2;
    svc[3] = t.service_time_3;
    if (t.arrival) begin
      best = 0;
      for (int i = 1; i < NUM_LINES; i++) begin
        if (line_fill[best] > line_fill[i]) begin
          best = i;
        end
      end
      r.joined_line = JOIN_W'(best);
      if (line_fill[best] >= LINE_DEPTH) begin
        r.arrival_dropped = 1'b1;
      end else begin
        slot = (head_idx[best] + line_fill[best]) % LINE_DEPTH;
        stamp_mem[best][slot] = tick_now;
        line_fill[best]++;
      end
    end
    for (int i = 0; i < NUM_LINES; i++) begin
      if (busy_left[i] != 0) begin
        busy_left[i]--;
      end else if (line_fill[i] != 0) begin
        waited = tick_now - stamp_mem[i][head_idx[i]];
        head_idx[i] = (head_idx[i] + 1) % LINE_DEPTH;
        line_fill[i]--;
        wait_total   = TOTAL_W'(add_clamped(64'(wait_total), 64'(waited), TOTAL_CAP));
        served_total = SERVED_W'(add_clamped(64'(served_total), 64'd1, SERVED_CAP));
        busy_left[i] = (i < SVC_INPUTS) ? 32'(64'(svc[i]) & SVC_MASK) : 0;
        r.started_this_tick++;
      end
    end
    queued = 0;
    for (int i = 0; i < NUM_LINES; i++) begin
      queued += line_fill[i];
    end
    length_total = TOTAL_W'(add_clamped(64'(length_total), 64'(queued), TOTAL_CAP));
    r.total_served = served_total;
    r.total_wait   = wait_total;
    r.total_length = length_total;
    tick_now++;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        for (int j = 0; j < LINE_DEPTH; j++) begin
          stamp_mem[i][j] = '0;
        end
        head_idx[i]  = 0;
        line_fill[i] = 0;
        busy_left[i] = 0;
      end
      tick_now     = '0;
      served_total = '0;
      wait_total   = '0;
      length_total = '0;
      report_q.delete();
      err_count = 0;
      pending   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $error("result item with no tick waiting for it");
          err_count++;
        end else begin
          want = report_q.pop_front();
          check_field("joined_line", 64'(want.joined_line), 64'(out_data.joined_line));
          check_field("arrival_dropped", 64'(want.arrival_dropped),
                      64'(out_data.arrival_dropped));
          check_field("started_this_tick", 64'(want.started_this_tick),
                      64'(out_data.started_this_tick));
          check_field("current_tick", 64'(want.current_tick),
                      64'(out_data.current_tick));
          check_field("total_served", 64'(want.total_served),
                      64'(out_data.total_served));
          check_field("total_wait", 64'(want.total_wait), 64'(out_data.total_wait));
          check_field("total_length", 64'(want.total_length),
                      64'(out_data.total_length));
        end
      end
      if (in_valid && in_ready) begin
        report_q.push_back(dispatch_tick(in_data));
      end
      pending = report_q.size();
    end
  end

endmodule

### tb/sv/join_shortest_queue_dispatcher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// join_shortest_queue_dispatcher_core_tb
// Stimulus and verdict for the join-shortest-queue dispatcher.
//
// A short directed run covers idle ticks, same-tick service, zero and maximum
// service times and ties between lines. Random ticks then alternate between
// flooding the lines until arrivals are dropped, draining them and mixed load,
// first with a slow receiver, then with a slow sender, then at full rate.
// A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module join_shortest_queue_dispatcher_core_tb;
  import jsq_pkg::*;

  localparam int NUM_LINES     = 4;
  localparam int LINE_DEPTH    = 16;
  localparam int SERVICE_WIDTH = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int TOTAL_ITEMS   = 750;

  typedef enum {FLOOD, DRAIN, MIXED} load_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  int   in_idle_pct  = 28;
  int   out_idle_pct = 50;
  int   sent_items   = 0;
  int   idle_cycles  = 0;
  int   fail_count;
  int   expected_left;

  jsq_in_if  in_chan ();
  jsq_out_if out_chan ();

  join_shortest_queue_dispatcher_core #(
    .NUM_LINES     (NUM_LINES),
    .LINE_DEPTH    (LINE_DEPTH),
    .SERVICE_WIDTH (SERVICE_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  jsq_dispatch_checker #(
    .NUM_LINES     (NUM_LINES),
    .LINE_DEPTH    (LINE_DEPTH),
    .SERVICE_WIDTH (SERVICE_WIDTH)
  ) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_data   (in_chan.data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data),
    .err_count (fail_count),
    .pending   (expected_left)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic jsq_in_t tick_item(logic arrival, logic [3:0] s0, logic [3:0] s1,
                                        logic [3:0] s2, logic [3:0] s3);
    jsq_in_t t;
    t.arrival        = arrival;
    t.service_time_0 = s0;
    t.service_time_1 = s1;
    t.service_time_2 = s2;
    t.service_time_3 = s3;
    return t;
  endfunction

  function automatic jsq_in_t random_tick(load_mode_t mode);
    int arrive_pct;
    int svc_lo;
    int svc_hi;
    case (mode)
      FLOOD: begin
        arrive_pct = 95;
        svc_lo     = 10;
        svc_hi     = 15;
      end
      DRAIN: begin
        arrive_pct = 10;
        svc_lo     = 0;
        svc_hi     = 3;
      end
      default: begin
        arrive_pct = 50;
        svc_lo     = 0;
        svc_hi     = 15;
      end
    endcase
    return tick_item($urandom_range(0, 99) < arrive_pct,
                     4'($urandom_range(svc_lo, svc_hi)), 4'($urandom_range(svc_lo, svc_hi)),
                     4'($urandom_range(svc_lo, svc_hi)), 4'($urandom_range(svc_lo, svc_hi)));
  endfunction

  task automatic send_tick(input jsq_in_t t);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= t;
    do begin
      @(posedge clk);
    end while (!(in_chan.valid && in_chan.ready));
    @(negedge clk);
    sent_items++;
  endtask

  // Load segments: floods fill every line until arrivals drop, drains empty them.
  task automatic run_random(input int upto);
    load_mode_t mode;
    int         seg_len;
    while (sent_items < upto) begin
      case ($urandom_range(0, 2))
        0: begin
          mode    = FLOOD;
          seg_len = $urandom_range(90, 150);
        end
        1: begin
          mode    = DRAIN;
          seg_len = $urandom_range(10, 40);
        end
        default: begin
          mode    = MIXED;
          seg_len = $urandom_range(20, 60);
        end
      endcase
      for (int k = 0; k < seg_len && sent_items < upto; k++) begin
        send_tick(random_tick(mode));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_tick(tick_item(1'b0, 4'd0, 4'd0, 4'd0, 4'd0));
    send_tick(tick_item(1'b1, 4'd0, 4'd0, 4'd0, 4'd0));
    repeat (12) send_tick(tick_item(1'b1, 4'd15, 4'd15, 4'd15, 4'd15));
    send_tick(tick_item(1'b1, 4'hA, 4'h5, 4'hA, 4'h5));
    send_tick(tick_item(1'b1, 4'h5, 4'hA, 4'h5, 4'hA));
    repeat (5) send_tick(tick_item(1'b0, 4'd0, 4'd0, 4'd0, 4'd0));
    send_tick(tick_item(1'b1, 4'd1, 4'd2, 4'd3, 4'd4));

    run_random(275);
    in_idle_pct  = 50;
    out_idle_pct = 28;
    run_random(525);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(TOTAL_ITEMS);
    in_chan.valid <= 1'b0;

    while (expected_left != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### join_shortest_queue_dispatcher_core.f
sv/jsq_pkg.sv
sv/jsq_if.sv
sv/jsq_ram.sv
sv/jsq_lane.sv
sv/jsq_merge.sv
sv/join_shortest_queue_dispatcher_core.sv
tb/sv/jsq_dispatch_checker.sv
tb/sv/join_shortest_queue_dispatcher_core_tb.sv
